>>> rtl/core/bha_pkg.sv
// ----------------------------------------------------------------------------
// Buddy heap allocator package
// Shared widths, codes, payload types and helper functions.
// ----------------------------------------------------------------------------
package bha_pkg;

   localparam int MAX_ORDER  = 10;
   localparam int ORD_W      = $clog2(MAX_ORDER + 1);
   localparam int OFF_W      = MAX_ORDER;
   localparam int IDX_W      = MAX_ORDER + 1;
   localparam int SIZE_W     = MAX_ORDER + 1;
   localparam int NODE_COUNT = 1 << IDX_W;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [1:0] ST_NO_SPACE  = 2'd2;
   localparam logic [1:0] ST_UNCLAIMED = 2'd3;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   // Node entry bits: bit 1 in use, bit 0 claimed.
   localparam logic [1:0] NODE_FREE    = 2'b00;
   localparam logic [1:0] NODE_USED    = 2'b10;
   localparam logic [1:0] NODE_CLAIMED = 2'b11;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_A_READ,
      S_A_EVAL,
      S_A_ADV,
      S_A_MARK,
      S_R_READ,
      S_R_EVAL,
      S_R_UP,
      S_R_UPEVAL,
      S_DONE
   } bha_state_type;

   typedef struct packed {
      logic              req_type;
      logic [10:0]       size_blocks;
      logic [3:0]        align_order;
      logic [9:0]        offset_blocks;
   } bha_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [9:0]        result_offset;
      logic [3:0]        block_order;
      logic              any_in_use;
   } bha_rsp_type;

   function automatic logic [SIZE_W-1:0] pow2(input logic [ORD_W-1:0] ord);
      pow2 = SIZE_W'(1) << ord;
   endfunction

   function automatic logic [OFF_W-1:0] low_mask(input logic [3:0] ord);
      logic [OFF_W-1:0] m;
      for (int i = 0; i < OFF_W; i++) begin
         m[i] = (4'(i) < ord);
      end
      low_mask = m;
   endfunction

endpackage

>>> rtl/core/buddy_heap_allocator.sv
// ----------------------------------------------------------------------------
// Buddy heap allocator
// Binary buddy allocator with a node bitmap in a single-port-write memory.
// ----------------------------------------------------------------------------
// An allocate reads and evaluates each tree node it visits, takes an advance step on
// each failed node and each step back up, then marks the ancestors of the claimed
// node and strobes the result. One request at a time: busy stays high until the
// result cycle ends. After reset and after every heap_order write a clearing pass
// over every node entry runs with busy high. Results are strobed and cannot stall.
module buddy_heap_allocator
   import bha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  bha_req_type req_data,
   output logic        rsp_valid,
   output bha_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);

   bha_state_type     state_ff, state_in;
   logic [ORD_W-1:0]  heap_order_ff, heap_order_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [ORD_W-1:0]  ord_ff, ord_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [3:0]        align_ff, align_in;
   logic [1:0]        status_ff, status_in;
   logic [OFF_W-1:0]  res_off_ff, res_off_in;
   logic [ORD_W-1:0]  res_ord_ff, res_ord_in;
   logic              root_used_ff, root_used_in;

   logic [1:0]        mem [NODE_COUNT];
   logic [1:0]        rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa, mem_ra;
   logic [1:0]        mem_wd;

   logic              csr_wr;
   logic [SIZE_W-1:0] req_size;
   logic              descend;
   logic              misaligned;
   logic [IDX_W-1:0]  rel_idx;

   // A register write is taken only when the block is idle and no request is offered.
   assign csr_ready = (state_ff == S_IDLE) & ~start;
   assign csr_wr    = csr_valid & csr_ready;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_data  = '{status: status_ff, result_offset: res_off_ff,
                        block_order: res_ord_ff, any_in_use: root_used_ff};

   assign req_size   = (req_data.size_blocks == '0) ? SIZE_W'(1) : req_data.size_blocks;
   assign descend    = (ord_ff != '0) && (pow2(ord_ff - ORD_W'(1)) >= size_ff);
   assign misaligned = |(off_ff & low_mask(align_ff));
   assign rel_idx    = IDX_W'(pow2(heap_order_ff - ord_ff)) + IDX_W'(off_ff >> ord_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:    if (clr_cnt_ff == '1) state_in = S_IDLE;
         S_IDLE: begin
            if (start) begin
               if (req_data.req_type == REQ_ALLOC) begin
                  state_in = (req_size > pow2(heap_order_ff)) ? S_DONE : S_A_READ;
               end else begin
                  state_in = (SIZE_W'(req_data.offset_blocks) >= pow2(heap_order_ff)) ?
                             S_DONE : S_R_READ;
               end
            end
         end
         S_A_READ:   state_in = S_A_EVAL;
         S_A_EVAL: begin
            if (rd_ff[0] || (pow2(ord_ff) < size_ff)) state_in = S_A_ADV;
            else if (descend) state_in = S_A_READ;
            else if (rd_ff[1] || misaligned) state_in = S_A_ADV;
            else state_in = S_A_MARK;
         end
         S_A_ADV: begin
            if (idx_ff == IDX_W'(1)) state_in = S_DONE;
            else if (!idx_ff[0]) state_in = S_A_READ;
         end
         S_A_MARK:   if (cur_ff == '0) state_in = S_DONE;
         S_R_READ:   state_in = (|(off_ff & low_mask(ord_ff))) ? S_DONE : S_R_EVAL;
         S_R_EVAL: begin
            if (rd_ff[0]) state_in = S_R_UP;
            else if (ord_ff == heap_order_ff) state_in = S_DONE;
            else state_in = S_R_READ;
         end
         S_R_UP:     state_in = (cur_ff == IDX_W'(1)) ? S_DONE : S_R_UPEVAL;
         S_R_UPEVAL: state_in = rd_ff[1] ? S_DONE : S_R_UP;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
      if (csr_wr) state_in = S_CLEAR;
   end

   // Datapath and memory control.
   always_comb begin
      heap_order_in = heap_order_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      clr_cnt_in    = clr_cnt_ff;
      ord_in        = ord_ff;
      off_in        = off_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      status_in     = status_ff;
      res_off_in    = res_off_ff;
      res_ord_in    = res_ord_ff;
      root_used_in  = root_used_ff;
      mem_we        = 1'b0;
      mem_wa        = cur_ff;
      mem_wd        = NODE_FREE;
      mem_ra        = idx_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + IDX_W'(1);
         end
         S_IDLE: begin
            status_in  = ST_OK;
            res_off_in = '0;
            res_ord_in = '0;
            size_in    = req_size;
            align_in   = req_data.align_order;
            idx_in     = IDX_W'(1);
            ord_in     = (req_data.req_type == REQ_ALLOC) ? heap_order_ff : '0;
            off_in     = (req_data.req_type == REQ_ALLOC) ? '0 : req_data.offset_blocks;
            if (req_data.req_type == REQ_ALLOC) begin
               if (req_size > pow2(heap_order_ff)) status_in = ST_TOO_LARGE;
            end else if (SIZE_W'(req_data.offset_blocks) >= pow2(heap_order_ff)) begin
               status_in = ST_UNCLAIMED;
            end
         end
         S_A_EVAL: begin
            if (rd_ff[0] || (pow2(ord_ff) < size_ff)) begin
               // Failed node: the advance step picks the next candidate.
            end else if (descend) begin
               idx_in = idx_ff << 1;
               ord_in = ord_ff - ORD_W'(1);
            end else if (!(rd_ff[1] || misaligned)) begin
               mem_we       = 1'b1;
               mem_wa       = idx_ff;
               mem_wd       = NODE_CLAIMED;
               res_off_in   = off_ff;
               res_ord_in   = ord_ff;
               root_used_in = 1'b1;
               cur_in       = idx_ff >> 1;
            end
         end
         S_A_ADV: begin
            if (idx_ff == IDX_W'(1)) begin
               status_in = ST_NO_SPACE;
            end else if (!idx_ff[0]) begin
               idx_in = idx_ff + IDX_W'(1);
               off_in = off_ff + OFF_W'(pow2(ord_ff));
            end else begin
               // Right child exhausted: climb and try the parent's sibling.
               idx_in = idx_ff >> 1;
               ord_in = ord_ff + ORD_W'(1);
               off_in = off_ff & ~OFF_W'(pow2(ord_ff));
            end
         end
         S_A_MARK: begin
            if (cur_ff != '0) begin
               mem_we = 1'b1;
               mem_wd = NODE_USED;
               cur_in = cur_ff >> 1;
            end
         end
         S_R_READ: begin
            mem_ra = rel_idx;
            cur_in = rel_idx;
            if (|(off_ff & low_mask(ord_ff))) status_in = ST_UNCLAIMED;
         end
         S_R_EVAL: begin
            if (rd_ff[0]) begin
               mem_we     = 1'b1;
               res_ord_in = ord_ff;
            end else if (ord_ff == heap_order_ff) begin
               status_in = ST_UNCLAIMED;
            end else begin
               ord_in = ord_ff + ORD_W'(1);
            end
         end
         S_R_UP: begin
            mem_ra = cur_ff ^ IDX_W'(1);
            if (cur_ff == IDX_W'(1)) root_used_in = 1'b0;
         end
         S_R_UPEVAL: begin
            if (!rd_ff[1]) begin
               mem_we = 1'b1;
               mem_wa = cur_ff >> 1;
               cur_in = cur_ff >> 1;
            end
         end
         default: begin
         end
      endcase
      if (csr_wr) begin
         heap_order_in = (csr_data > 4'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : ORD_W'(csr_data);
         clr_cnt_in    = '0;
         root_used_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         heap_order_ff <= ORD_W'(MAX_ORDER);
         clr_cnt_ff    <= '0;
         root_used_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_order_ff <= heap_order_in;
         clr_cnt_ff    <= clr_cnt_in;
         root_used_ff  <= root_used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cur_ff     <= cur_in;
      ord_ff     <= ord_in;
      off_ff     <= off_in;
      size_ff    <= size_in;
      align_ff   <= align_in;
      status_ff  <= status_in;
      res_off_ff <= res_off_in;
      res_ord_ff <= res_ord_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held for two cycles");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
         (rsp_data.result_offset == '0 && rsp_data.block_order == '0))
      else $error("failed result carries offset or order");

   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (busy && !rsp_data.any_in_use)) else $error("register write did not clear");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Buddy heap allocator testbench
// Drives allocate and release requests through the command port under several
// heap orders, predicts each result from a model of the node tree, and checks
// every strobed result field by field in order.
// ----------------------------------------------------------------------------
module tb_top
   import bha_pkg::*;
();

   class heap_scoreboard;
      bit          node_busy[NODE_COUNT];
      bit          node_taken[NODE_COUNT];
      int          order;
      bha_rsp_type pending[$];
      int          live[$];
      int          errors;
      int          grants;
      int          releases;

      function new();
         order  = MAX_ORDER;
         errors = 0;
      endfunction

      function void set_order(logic [3:0] value);
         order = (value > MAX_ORDER) ? MAX_ORDER : int'(value);
         foreach (node_busy[i]) begin
            node_busy[i]  = 0;
            node_taken[i] = 0;
         end
         live.delete();
      endfunction

      function int find_node(int idx, int ord, int off, int size, int align);
         int r;
         if (node_taken[idx]) return 0;
         if ((1 << ord) < size) return 0;
         if (ord > 0 && (1 << (ord - 1)) >= size) begin
            r = find_node(idx * 2, ord - 1, off, size, align);
            if (r == 0) r = find_node(idx * 2 + 1, ord - 1, off + (1 << (ord - 1)), size, align);
            return r;
         end
         if (node_busy[idx]) return 0;
         if ((off & ((1 << align) - 1)) != 0) return 0;
         return idx;
      endfunction

      function void note_request(bha_req_type rq);
         bha_rsp_type e;
         int size, idx, lvl, p, off, found;
         e = '0;
         if (rq.req_type == REQ_ALLOC) begin
            size = (rq.size_blocks == 0) ? 1 : int'(rq.size_blocks);
            if (size > (1 << order)) begin
               e.status = ST_TOO_LARGE;
            end else begin
               idx = find_node(1, order, 0, size, int'(rq.align_order));
               if (idx == 0) begin
                  e.status = ST_NO_SPACE;
               end else begin
                  lvl = $clog2(idx + 1) - 1;
                  e.status        = ST_OK;
                  e.block_order   = 4'(order - lvl);
                  e.result_offset = 10'((idx - (1 << lvl)) << (order - lvl));
                  node_taken[idx] = 1;
                  for (p = idx; p != 0; p = p >> 1) node_busy[p] = 1;
                  live.push_back(int'(e.result_offset));
                  grants++;
               end
            end
         end else begin
            off   = int'(rq.offset_blocks);
            found = 0;
            if (off < (1 << order)) begin
               for (int o = 0; o <= order; o++) begin
                  if ((off & ((1 << o) - 1)) != 0) break;
                  idx = (1 << (order - o)) + (off >> o);
                  if (node_taken[idx]) begin
                     found = idx;
                     e.block_order = 4'(o);
                     break;
                  end
               end
            end
            if (found == 0) begin
               e.status      = ST_UNCLAIMED;
               e.block_order = '0;
            end else begin
               node_taken[found] = 0;
               node_busy[found]  = 0;
               p = found >> 1;
               while (p != 0 && !node_busy[p * 2] && !node_busy[p * 2 + 1]) begin
                  node_busy[p] = 0;
                  p = p >> 1;
               end
               foreach (live[i]) if (live[i] == off) begin
                  live.delete(i);
                  break;
               end
               releases++;
            end
         end
         e.any_in_use = node_busy[1];
         pending.push_back(e);
      endfunction

      function void check_result(bha_rsp_type got);
         bha_rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
            errors++;
         end
         if (got.result_offset !== e.result_offset) begin
            $display("%0t: offset expected %0d got %0d", $time, e.result_offset,
                     got.result_offset);
            errors++;
         end
         if (got.block_order !== e.block_order) begin
            $display("%0t: order expected %0d got %0d", $time, e.block_order,
                     got.block_order);
            errors++;
         end
         if (got.any_in_use !== e.any_in_use) begin
            $display("%0t: in-use expected %0d got %0d", $time, e.any_in_use,
                     got.any_in_use);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   bha_req_type req;
   logic        rsp_valid;
   bha_rsp_type rsp;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_data;

   heap_scoreboard sb = new();
   int sent;
   int idle_pct;

   buddy_heap_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req),
      .rsp_valid(rsp_valid), .rsp_data(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp);
   end

   task automatic send_beat(bha_req_type rq);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 0;
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      @(negedge clock);
      start = 1;
      req   = rq;
      do @(posedge clock); while (busy);
      sb.note_request(rq);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_order(logic [3:0] value);
      drain();
      @(negedge clock);
      csr_valid = 1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_order(value);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic bha_req_type make_alloc(int size, int align);
      bha_req_type rq;
      rq = '0;
      rq.req_type      = REQ_ALLOC;
      rq.size_blocks   = 11'(size);
      rq.align_order   = 4'(align);
      rq.offset_blocks = 10'($urandom);
      return rq;
   endfunction

   function automatic bha_req_type make_release(int off);
      bha_req_type rq;
      rq = '0;
      rq.req_type      = REQ_RELEASE;
      rq.size_blocks   = 11'($urandom);
      rq.align_order   = 4'($urandom);
      rq.offset_blocks = 10'(off);
      return rq;
   endfunction

   function automatic bha_req_type make_random();
      int h, r, size, align;
      h = 1 << sb.order;
      if ($urandom_range(99) < 55) begin
         r = $urandom_range(99);
         if (r < 70)      size = $urandom_range(1, (h / 4 > 1) ? h / 4 : 1);
         else if (r < 80) size = 0;
         else if (r < 90) size = $urandom_range(1, h);
         else             size = $urandom_range(0, 2047);
         align = ($urandom_range(99) < 80) ? $urandom_range(0, 2) : $urandom_range(0, 15);
         return make_alloc(size, align);
      end
      if (sb.live.size() != 0 && $urandom_range(99) < 80)
         return make_release(sb.live[$urandom_range(0, sb.live.size() - 1)]);
      if ($urandom_range(1)) return make_release($urandom_range(0, h - 1));
      return make_release($urandom_range(0, 1023));
   endfunction

   initial begin
      logic [3:0] orders[9];
      int counts[9];
      orders    = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd5, 4'd12, 4'd7, 4'd2, 4'd10};
      counts    = '{140, 30, 40, 50, 150, 40, 150, 100, 40};
      reset     = 1;
      start     = 0;
      req       = '0;
      csr_valid = 0;
      csr_data  = '0;
      sent      = 0;
      idle_pct  = 17;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Corner cases on the reset heap of 1024 blocks.
      send_beat(make_alloc(1024, 0));
      send_beat(make_alloc(1, 0));
      send_beat(make_release(512));
      send_beat(make_release(0));
      send_beat(make_alloc(2047, 0));
      send_beat(make_alloc(1025, 3));
      send_beat(make_alloc(0, 0));
      send_beat(make_alloc(1, 15));
      send_beat(make_alloc(1, 0));
      send_beat(make_alloc(3, 1));
      send_beat(make_alloc(512, 9));
      send_beat(make_alloc(256, 10));
      send_beat(make_release(1023));
      send_beat(make_release(1));
      send_beat(make_release(0));
      send_beat(make_release(512));
      send_beat(make_alloc(5, 2));
      send_beat(make_release(sb.live.size() ? sb.live[0] : 0));
      // A rewrite with live allocations drops them all.
      write_order(4'd2);
      send_beat(make_alloc(4, 0));
      send_beat(make_release(1023));
      send_beat(make_release(4));
      send_beat(make_release(0));

      for (int ph = 0; ph < 9; ph++) begin
         write_order(orders[ph]);
         for (int n = 0; n < counts[ph]; n++) begin
            idle_pct = (sent < 300) ? 17 : (sent < 600) ? 63 : 0;
            send_beat(make_random());
            if (ph == 4 && n == 70) drain();
         end
      end

      drain();
      repeat (50) @(posedge clock);
      $display("Ran %0d requests over heap orders 0 to 10: %0d grants, %0d releases.",
               sent, sb.grants, sb.releases);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #600_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/bha_pkg.sv
rtl/core/buddy_heap_allocator.sv
tb/tb_top.sv
